>>> sv/markup_comment_stripper_unit_defines.svh
// assertion macros for the markup comment stripper
// used by the top level only, no other dependencies
`ifndef MARKUP_COMMENT_STRIPPER_UNIT_DEFINES_SVH
`define MARKUP_COMMENT_STRIPPER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define MSC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define MSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define MSC_ASSERT_SAME(lbl, clk, rst_n, ante, cons)

`define MSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> sv/msc_pkg.sv
// shared types, character codes and the helper function of the comment stripper
// no dependencies
package msc_pkg;

    localparam int MaxResults = 4;
    localparam int CountW     = $clog2(MaxResults + 1);

    localparam logic [7:0] CharLt   = 8'h3C;
    localparam logic [7:0] CharBang = 8'h21;
    localparam logic [7:0] CharDash = 8'h2D;
    localparam logic [7:0] CharGt   = 8'h3E;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       last;
    } out_beat_t;

    typedef struct packed {
        logic                        valid;
        logic                        closing;
        logic                        idle;
        logic [CountW-1:0]           count;
        out_beat_t [MaxResults-1:0]  entries;
    } res_list_t;

    typedef struct packed {
        logic              take;
        logic [CountW-1:0] level;
    } emit_stat_t;

    // n-th byte of the opener "<!--"
    function automatic logic [7:0] opener_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = CharLt;
            2'd1:    b = CharBang;
            default: b = CharDash;
        endcase
        return b;
    endfunction

endpackage

>>> sv/msc_if.sv
// valid/ready channels of the comment stripper, text side and result side
// depends on msc_pkg
interface msc_in_if;
    logic               valid;
    logic               ready;
    msc_pkg::in_beat_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface msc_out_if;
    logic               valid;
    logic               ready;
    msc_pkg::out_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> sv/msc_matcher.sv
// input register, opener/closer matcher and result list builder
// depends on msc_pkg and msc_if
module msc_matcher (
    input  logic                 clk,
    input  logic                 rst_n,
    msc_in_if.sink               text,
    input  msc_pkg::emit_stat_t  stat,
    output msc_pkg::res_list_t   list
);
    import msc_pkg::*;

    typedef enum logic [2:0] {
        PH_OUT          = 3'd0,
        PH_LT           = 3'd1,
        PH_LT_BANG      = 3'd2,
        PH_LT_BANG_DASH = 3'd3,
        PH_IN           = 3'd4,
        PH_IN_DASH      = 3'd5,
        PH_IN_DASH2     = 3'd6
    } phase_t;

    phase_t     phase_reg;
    phase_t     phase_next;
    logic       pend_reg;
    in_beat_t   beat_reg;
    logic       load;

    out_beat_t [MaxResults-1:0] entries;
    logic [CountW-1:0]          n;

    // bytes of a partial opener held in a phase
    function automatic logic [1:0] held_count(input phase_t ph);
        logic [1:0] h;
        case (ph)
            PH_LT:           h = 2'd1;
            PH_LT_BANG:      h = 2'd2;
            PH_LT_BANG_DASH: h = 2'd3;
            default:         h = 2'd0;
        endcase
        return h;
    endfunction

    assign load       = pend_reg && stat.take;
    assign text.ready = !pend_reg || stat.take;

    always_comb
    begin
        logic [7:0] b;
        logic [1:0] h;
        logic [1:0] h2;
        b          = beat_reg.in_byte;
        h          = held_count(phase_reg);
        h2         = 2'd0;
        n          = '0;
        entries    = '0;
        phase_next = phase_reg;
        case (phase_reg)
            PH_IN:
            begin
                phase_next = (b == CharDash) ? PH_IN_DASH : PH_IN;
            end
            PH_IN_DASH:
            begin
                phase_next = (b == CharDash) ? PH_IN_DASH2 : PH_IN;
            end
            PH_IN_DASH2:
            begin
                if (b == CharGt)
                    phase_next = PH_OUT;
                else if (b == CharDash)
                    phase_next = PH_IN_DASH2;
                else
                    phase_next = PH_IN;
            end
            default:
            begin
                // outside a comment, unused code acts as nothing held
                if (b == opener_byte(h))
                begin
                    if (h == 2'd3)
                        phase_next = PH_IN_DASH2;
                    else
                        phase_next = phase_t'({1'b0, h} + 3'd1);
                end
                else
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        if (2'(i) < h)
                        begin
                            entries[n[1:0]] = '{out_byte: opener_byte(2'(i)),
                                                has_byte: 1'b1, last: 1'b0};
                            n = n + 1'b1;
                        end
                    end
                    if (b == CharLt)
                        phase_next = PH_LT;
                    else
                    begin
                        entries[n[1:0]] = '{out_byte: b, has_byte: 1'b1, last: 1'b0};
                        n          = n + 1'b1;
                        phase_next = PH_OUT;
                    end
                end
            end
        endcase

        if (beat_reg.end_of_text)
        begin
            // flush a partial opener, close the text
            h2 = held_count(phase_next);
            for (int i = 0; i < 3; i++)
            begin
                if (2'(i) < h2)
                begin
                    entries[n[1:0]] = '{out_byte: opener_byte(2'(i)),
                                        has_byte: 1'b1, last: 1'b0};
                    n = n + 1'b1;
                end
            end
            if (n == '0)
            begin
                entries[0] = '{out_byte: 8'h00, has_byte: 1'b0, last: 1'b0};
                n          = n + 1'b1;
            end
            entries[2'(n - 1'b1)].last = 1'b1;
            phase_next = PH_OUT;
        end
    end

    assign list.valid   = pend_reg;
    assign list.closing = beat_reg.end_of_text;
    assign list.idle    = (phase_reg == PH_OUT);
    assign list.count   = n;
    assign list.entries = entries;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_OUT;
            pend_reg  <= 1'b0;
            beat_reg  <= '0;
        end
        else
        begin
            if (load)
                phase_reg <= phase_next;
            if (text.ready)
                pend_reg <= text.valid;
            if (text.valid && text.ready)
                beat_reg <= text.data;
        end
    end

endmodule

>>> sv/msc_emitter.sv
// result register that hands out a result list one beat at a time
// depends on msc_pkg and msc_if
module msc_emitter (
    input  logic                 clk,
    input  logic                 rst_n,
    input  msc_pkg::res_list_t   list,
    output msc_pkg::emit_stat_t  stat,
    msc_out_if.source            stripped
);
    import msc_pkg::*;

    logic [CountW-1:0]          level_reg;
    logic [CountW-1:0]          level_next;
    out_beat_t [MaxResults-1:0] slot_reg;
    out_beat_t [MaxResults-1:0] slot_next;
    logic                       pop;
    logic                       take;
    logic                       load;

    assign stripped.valid = (level_reg != '0);
    assign stripped.data  = slot_reg[0];
    assign pop            = stripped.valid && stripped.ready;

    // room for a new list once the last held beat leaves
    assign take = (list.count == '0) || (level_reg == '0)
                  || ((level_reg == CountW'(1)) && stripped.ready);
    assign load = list.valid && take && (list.count != '0);

    assign stat.take  = take;
    assign stat.level = level_reg;

    always_comb
    begin
        slot_next  = slot_reg;
        level_next = level_reg;
        if (load)
        begin
            slot_next  = list.entries;
            level_next = list.count;
        end
        else if (pop)
        begin
            for (int i = 0; i < MaxResults - 1; i++)
                slot_next[i] = slot_reg[i+1];
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
            slot_reg  <= '0;
        end
        else
        begin
            level_reg <= level_next;
            slot_reg  <= slot_next;
        end
    end

endmodule

>>> sv/markup_comment_stripper_unit.sv
// markup comment stripper: removes <!-- ... --> comments from a byte stream
// top level, depends on msc_pkg, msc_if, msc_matcher, msc_emitter and the defines header
//
// text channel: one byte per beat with an end-of-text flag on the final byte
// stripped channel: one result per beat (byte, has-byte flag, last flag)
// each text beat is registered, matched against the opener and closer and
// turned into a list of zero to four results that the result register hands
// out one beat per cycle while the stripped channel is ready
// a text beat passes the input register and then the result register before
// its first result is offered; one text beat per cycle while each beat makes at
// most one result and the stripped channel is ready; a beat that makes several
// results holds the text channel until its last result leaves the single result
// register; bytes inside a comment make no result and pass at one per cycle
// reset clears the matcher to outside with nothing held and empties both registers
// a stall on the stripped channel holds the offered result; the text channel
// keeps taking beats until the input register holds one that makes results
`include "markup_comment_stripper_unit_defines.svh"

module markup_comment_stripper_unit (
    input  logic       clk,
    input  logic       rst_n,
    msc_in_if.sink     text,
    msc_out_if.source  stripped
);
    import msc_pkg::*;

    res_list_t  list;
    emit_stat_t stat;

    msc_matcher u_matcher (
        .clk   (clk),
        .rst_n (rst_n),
        .text  (text),
        .stat  (stat),
        .list  (list)
    );

    msc_emitter u_emitter (
        .clk      (clk),
        .rst_n    (rst_n),
        .list     (list),
        .stat     (stat),
        .stripped (stripped)
    );

    `MSC_ASSERT_SAME(a_close_has_result, clk, rst_n, list.valid && list.closing,
                     list.count != '0)
    `MSC_ASSERT_NEXT(a_close_resets, clk, rst_n,
                     list.valid && list.closing && stat.take, list.idle)
    `MSC_ASSERT_SAME(a_level_bound, clk, rst_n, 1'b1, stat.level <= CountW'(MaxResults))
    `MSC_ASSERT_SAME(a_no_overrun, clk, rst_n,
                     list.valid && (list.count != '0) && (stat.level > CountW'(1)),
                     !stat.take)

endmodule
